// ===== rtl/b2b_pkg.sv =====
// constants, types and helpers for the blake2b compression engine
package b2b_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD_H   = 2'd0,
        CMD_LOAD_M   = 2'd1,
        CMD_LOAD_T   = 2'd2,
        CMD_COMPRESS = 2'd3
    } cmd_t;

    localparam int WORD_W    = 64;
    localparam int H_WORDS   = 8;
    localparam int M_WORDS   = 16;
    localparam int T_WORDS   = 4;
    localparam int V_WORDS   = 16;
    localparam int LANES     = 4;
    localparam int SIG_ROWS  = 10;
    localparam int HIDX_W    = $clog2(H_WORDS);
    localparam int MIDX_W    = $clog2(M_WORDS);
    localparam int TIDX_W    = $clog2(T_WORDS);
    localparam int ROW_W     = $clog2(SIG_ROWS);

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t IV [H_WORDS] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [MIDX_W-1:0] SIGMA [SIG_ROWS][M_WORDS] = '{
        '{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
        '{14, 10,  4,  8,  9, 15, 13,  6,  1, 12,  0,  2, 11,  7,  5,  3},
        '{11,  8, 12,  0,  5,  2, 15, 13, 10, 14,  3,  6,  7,  1,  9,  4},
        '{ 7,  9,  3,  1, 13, 12, 11, 14,  2,  6,  5, 10,  4,  0, 15,  8},
        '{ 9,  0,  5,  7,  2,  4, 10, 15, 14,  1, 11, 12,  6,  8,  3, 13},
        '{ 2, 12,  6, 10,  0, 11,  8,  3,  4, 13,  7,  5, 15, 14,  1,  9},
        '{12,  5,  1, 15, 14, 13,  4, 10,  0,  7,  6,  3,  9,  2,  8, 11},
        '{13, 11,  7, 14, 12,  1,  3,  9,  5,  0, 15,  4,  8,  6,  2, 10},
        '{ 6, 15, 14,  9, 11,  3,  0,  8, 12,  2, 13,  7,  1,  4, 10,  5},
        '{10,  2,  8,  4,  7,  6,  1,  5, 15, 11,  9, 14,  3, 12, 13,  0}
    };

    // rotate right by a constant amount
    function automatic word_t rotr64(word_t x, int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    // message word for a lane: position is {diag, lane, second}
    function automatic logic [MIDX_W-1:0] msg_sel(logic [ROW_W-1:0] row, logic diag,
                                                  logic [1:0] lane, logic second);
        return SIGMA[row][{diag, lane, second}];
    endfunction

endpackage

// ===== rtl/blake2b_compress_top.sv =====
// blake2b compression engine: word loads, iterative g mixing, chaining word output
// load requests return nothing
// a compress request passes through the prime, run and final states before the first result
// then 8 results, one per cycle while m_tready is high; s_tready is low until the last is taken
// four g lanes each do one quarter of g per cycle
// reset clears the sequencer and the output valid; stored words are undefined until loaded
module blake2b_compress_top
    import b2b_pkg::*;
#(
    parameter int ROUNDS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // word_value
    input  logic [5:0]  s_tuser,   // command [1:0], word_index [5:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // hash_value
    output logic [2:0]  m_tuser,   // hash_index
    output logic        m_tlast
);

    localparam int RCW = $clog2(ROUNDS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_RUN,
        ST_FINAL,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    logic [RCW-1:0]       round_reg;
    logic [ROW_W-1:0]     row_reg;
    logic                 diag_reg;
    logic [1:0]           phase_reg;
    logic                 m_tvalid_reg;
    logic                 m_tlast_reg;
    logic [HIDX_W-1:0]    m_tuser_reg;
    word_t                m_tdata_reg;

    word_t                chain_reg [H_WORDS];
    word_t                tf_reg    [T_WORDS];
    word_t                v_reg     [V_WORDS];
    word_t                msg_mem   [M_WORDS];
    word_t                mx_reg    [LANES];
    word_t                my_reg    [LANES];

    word_t                v_next    [V_WORDS];
    word_t                h_new     [H_WORDS];
    logic [ROW_W-1:0]     next_row;
    logic [ROW_W-1:0]     rd_row;
    logic                 rd_diag;
    logic [MIDX_W-1:0]    rd_addr0;
    logic [MIDX_W-1:0]    rd_addr1;
    logic                 in_req;
    logic                 out_req;
    cmd_t                 in_cmd;
    logic [MIDX_W-1:0]    in_idx;
    logic                 half_done;
    logic                 rounds_done;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign in_req   = s_tvalid && s_tready;
    assign out_req  = m_tvalid_reg && m_tready;
    assign in_cmd   = cmd_t'(s_tuser[1:0]);
    assign in_idx   = s_tuser[5:2];

    assign next_row    = (row_reg == ROW_W'(SIG_ROWS - 1)) ? '0 : row_reg + 1'b1;
    assign half_done   = (state_reg == ST_RUN) && (phase_reg == 2'd3);
    assign rounds_done = half_done && diag_reg && (round_reg == RCW'(ROUNDS - 1));

    // message prefetch: phases 0/1 fetch second words of this half round,
    // phases 2/3 fetch first words of the following one (of the first one while priming)
    always_comb begin
        if ((state_reg == ST_RUN) && phase_reg[1]) begin
            rd_row  = diag_reg ? next_row : row_reg;
            rd_diag = !diag_reg;
        end else begin
            rd_row  = row_reg;
            rd_diag = diag_reg;
        end
        rd_addr0 = msg_sel(rd_row, rd_diag, {phase_reg[0], 1'b0}, !phase_reg[1]);
        rd_addr1 = msg_sel(rd_row, rd_diag, {phase_reg[0], 1'b1}, !phase_reg[1]);
    end

    // four g lanes, one quarter step each per cycle
    always_comb begin
        logic [3:0] ia, ib, ic, id;
        word_t      a, b, c, d;
        v_next = v_reg;
        for (int i = 0; i < LANES; i++) begin
            ia = 4'(i);
            ib = diag_reg ? 4'(4 + ((i + 1) % 4))  : 4'(4 + i);
            ic = diag_reg ? 4'(8 + ((i + 2) % 4))  : 4'(8 + i);
            id = diag_reg ? 4'(12 + ((i + 3) % 4)) : 4'(12 + i);
            a  = v_reg[ia];
            b  = v_reg[ib];
            c  = v_reg[ic];
            d  = v_reg[id];
            unique case (phase_reg)
                2'd0: begin
                    a = a + b + mx_reg[i];
                    d = rotr64(d ^ a, 32);
                end
                2'd1: begin
                    c = c + d;
                    b = rotr64(b ^ c, 24);
                end
                2'd2: begin
                    a = a + b + my_reg[i];
                    d = rotr64(d ^ a, 16);
                end
                default: begin
                    c = c + d;
                    b = rotr64(b ^ c, 63);
                end
            endcase
            v_next[ia] = a;
            v_next[ib] = b;
            v_next[ic] = c;
            v_next[id] = d;
        end
    end

    always_comb begin
        for (int i = 0; i < H_WORDS; i++) begin
            h_new[i] = chain_reg[i] ^ v_reg[i] ^ v_reg[i + H_WORDS];
        end
    end

    // word stores and work vector
    always_ff @(posedge aclk) begin
        if (in_req) begin
            unique case (in_cmd)
                CMD_LOAD_H: begin
                    if (in_idx < MIDX_W'(H_WORDS)) begin
                        chain_reg[in_idx[HIDX_W-1:0]] <= s_tdata;
                    end
                end
                CMD_LOAD_M: begin
                    msg_mem[in_idx] <= s_tdata;
                end
                CMD_LOAD_T: begin
                    if (in_idx < MIDX_W'(T_WORDS)) begin
                        tf_reg[in_idx[TIDX_W-1:0]] <= s_tdata;
                    end
                end
                default: begin
                    for (int i = 0; i < H_WORDS; i++) begin
                        v_reg[i] <= chain_reg[i];
                    end
                    for (int i = 0; i < T_WORDS; i++) begin
                        v_reg[H_WORDS + i]     <= IV[i];
                        v_reg[12 + i]          <= IV[T_WORDS + i] ^ tf_reg[i];
                    end
                end
            endcase
        end
        if (state_reg == ST_RUN) begin
            v_reg <= v_next;
        end
        if ((state_reg == ST_PRIME) || (state_reg == ST_RUN)) begin
            unique case (phase_reg)
                2'd0: begin
                    my_reg[0] <= msg_mem[rd_addr0];
                    my_reg[1] <= msg_mem[rd_addr1];
                end
                2'd1: begin
                    my_reg[2] <= msg_mem[rd_addr0];
                    my_reg[3] <= msg_mem[rd_addr1];
                end
                2'd2: begin
                    mx_reg[0] <= msg_mem[rd_addr0];
                    mx_reg[1] <= msg_mem[rd_addr1];
                end
                default: begin
                    mx_reg[2] <= msg_mem[rd_addr0];
                    mx_reg[3] <= msg_mem[rd_addr1];
                end
            endcase
        end
        if (state_reg == ST_FINAL) begin
            chain_reg <= h_new;
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            round_reg    <= '0;
            row_reg      <= '0;
            diag_reg     <= 1'b0;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            m_tuser_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_req && (in_cmd == CMD_COMPRESS)) begin
                        state_reg <= ST_PRIME;
                        round_reg <= '0;
                        row_reg   <= '0;
                        diag_reg  <= 1'b0;
                        phase_reg <= 2'd2;
                    end
                end
                ST_PRIME: begin
                    phase_reg <= phase_reg + 1'b1;
                    if (phase_reg == 2'd3) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    phase_reg <= phase_reg + 1'b1;
                    if (half_done) begin
                        diag_reg <= !diag_reg;
                        if (diag_reg) begin
                            row_reg   <= next_row;
                            round_reg <= round_reg + 1'b1;
                        end
                    end
                    if (rounds_done) begin
                        state_reg <= ST_FINAL;
                        round_reg <= '0;
                    end
                end
                ST_FINAL: begin
                    state_reg    <= ST_EMIT;
                    m_tvalid_reg <= 1'b1;
                    m_tuser_reg  <= '0;
                    m_tlast_reg  <= 1'b0;
                    m_tdata_reg  <= h_new[0];
                end
                ST_EMIT: begin
                    if (out_req) begin
                        if (m_tlast_reg) begin
                            state_reg    <= ST_IDLE;
                            m_tvalid_reg <= 1'b0;
                            m_tlast_reg  <= 1'b0;
                        end else begin
                            m_tuser_reg <= m_tuser_reg + 1'b1;
                            m_tdata_reg <= chain_reg[m_tuser_reg + 1'b1];
                            m_tlast_reg <= (m_tuser_reg == HIDX_W'(H_WORDS - 2));
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_idle_no_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("result pending while accepting requests");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == 3'd7))
        else $error("last flag on wrong chaining word");

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (round_reg < RCW'(ROUNDS)))
        else $error("round counter overrun");

    a_compress_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_req && (in_cmd == CMD_COMPRESS)) |=> (state_reg == ST_PRIME))
        else $error("compress request did not start the engine");

    a_back_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_req && m_tlast) |=> (s_tready && (round_reg == '0)))
        else $error("engine not idle after last word");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the blake2b compression engine over its stream ports
`timescale 1ns / 1ps

module testbench;
    import b2b_pkg::*;

    localparam int NUM_ROUNDS  = 12;
    localparam int RANDOM_REQS = 230;
    localparam int CALM_AFTER  = 190;
    localparam int IDLE_LIMIT  = 1000;
    localparam int TAIL_CYCLES = 120;
    localparam logic [63:0] ONES = {64{1'b1}};

    localparam logic [63:0] IV_TAB [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam int PERM_TAB [10][16] = '{
        '{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
        '{14, 10,  4,  8,  9, 15, 13,  6,  1, 12,  0,  2, 11,  7,  5,  3},
        '{11,  8, 12,  0,  5,  2, 15, 13, 10, 14,  3,  6,  7,  1,  9,  4},
        '{ 7,  9,  3,  1, 13, 12, 11, 14,  2,  6,  5, 10,  4,  0, 15,  8},
        '{ 9,  0,  5,  7,  2,  4, 10, 15, 14,  1, 11, 12,  6,  8,  3, 13},
        '{ 2, 12,  6, 10,  0, 11,  8,  3,  4, 13,  7,  5, 15, 14,  1,  9},
        '{12,  5,  1, 15, 14, 13,  4, 10,  0,  7,  6,  3,  9,  2,  8, 11},
        '{13, 11,  7, 14, 12,  1,  3,  9,  5,  0, 15,  4,  8,  6,  2, 10},
        '{ 6, 15, 14,  9, 11,  3,  0,  8, 12,  2, 13,  7,  1,  4, 10,  5},
        '{10,  2,  8,  4,  7,  6,  1,  5, 15, 11,  9, 14,  3, 12, 13,  0}
    };

    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  idx;
        logic [63:0] val;
    } req_row_t;

    typedef struct {
        logic [2:0]  idx;
        logic [63:0] value;
        logic        last;
    } hash_word_t;

    // runs after every word has been loaded once with zero
    localparam req_row_t DIRECTED [18] = '{
        '{CMD_COMPRESS, 4'd15, ONES},
        '{CMD_COMPRESS, 4'd0,  64'd0},
        '{CMD_LOAD_H,   4'd0,  ONES},
        '{CMD_LOAD_H,   4'd7,  ONES},
        '{CMD_LOAD_H,   4'd8,  64'h0123_4567_89ab_cdef},
        '{CMD_LOAD_H,   4'd15, 64'd0},
        '{CMD_LOAD_M,   4'd0,  ONES},
        '{CMD_LOAD_M,   4'd15, ONES},
        '{CMD_LOAD_T,   4'd0,  ONES},
        '{CMD_LOAD_T,   4'd3,  ONES},
        '{CMD_LOAD_T,   4'd4,  64'h5555_5555_5555_5555},
        '{CMD_LOAD_T,   4'd15, ONES},
        '{CMD_COMPRESS, 4'd7,  64'haaaa_aaaa_aaaa_aaaa},
        '{CMD_LOAD_M,   4'd5,  64'h8000_0000_0000_0000},
        '{CMD_LOAD_M,   4'd10, 64'd1},
        '{CMD_LOAD_T,   4'd2,  ONES},
        '{CMD_LOAD_T,   4'd0,  64'd128},
        '{CMD_COMPRESS, 4'd3,  64'd0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata  = '0;
    logic [5:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    logic [63:0] chain_h [8];
    logic [63:0] msg_m [16];
    logic [63:0] ctr_t [4];
    logic [63:0] work_v [16];
    hash_word_t  expected_words [$];
    int          fail_count  = 0;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    bit          calm        = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    blake2b_compress_top #(
        .ROUNDS(NUM_ROUNDS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic void g_mix(int a, int b, int c, int d, logic [63:0] x, logic [63:0] y);
        work_v[a] = work_v[a] + work_v[b] + x;
        work_v[d] = ror64(work_v[d] ^ work_v[a], 32);
        work_v[c] = work_v[c] + work_v[d];
        work_v[b] = ror64(work_v[b] ^ work_v[c], 24);
        work_v[a] = work_v[a] + work_v[b] + y;
        work_v[d] = ror64(work_v[d] ^ work_v[a], 16);
        work_v[c] = work_v[c] + work_v[d];
        work_v[b] = ror64(work_v[b] ^ work_v[c], 63);
    endfunction

    function automatic void compress_block();
        int row;
        logic [63:0] h_new;
        for (int i = 0; i < 8; i++) begin
            work_v[i]     = chain_h[i];
            work_v[i + 8] = IV_TAB[i];
        end
        for (int i = 0; i < 4; i++) begin
            work_v[12 + i] ^= ctr_t[i];
        end
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            row = r % 10;
            g_mix(0, 4,  8, 12, msg_m[PERM_TAB[row][0]],  msg_m[PERM_TAB[row][1]]);
            g_mix(1, 5,  9, 13, msg_m[PERM_TAB[row][2]],  msg_m[PERM_TAB[row][3]]);
            g_mix(2, 6, 10, 14, msg_m[PERM_TAB[row][4]],  msg_m[PERM_TAB[row][5]]);
            g_mix(3, 7, 11, 15, msg_m[PERM_TAB[row][6]],  msg_m[PERM_TAB[row][7]]);
            g_mix(0, 5, 10, 15, msg_m[PERM_TAB[row][8]],  msg_m[PERM_TAB[row][9]]);
            g_mix(1, 6, 11, 12, msg_m[PERM_TAB[row][10]], msg_m[PERM_TAB[row][11]]);
            g_mix(2, 7,  8, 13, msg_m[PERM_TAB[row][12]], msg_m[PERM_TAB[row][13]]);
            g_mix(3, 4,  9, 14, msg_m[PERM_TAB[row][14]], msg_m[PERM_TAB[row][15]]);
        end
        for (int i = 0; i < 8; i++) begin
            h_new = chain_h[i] ^ work_v[i] ^ work_v[i + 8];
            chain_h[i] = h_new;
            expected_words.push_back('{3'(i), h_new, (i == 7)});
        end
    endfunction

    function automatic void predict_request(cmd_t cmd, logic [3:0] idx, logic [63:0] val);
        case (cmd)
            CMD_LOAD_H: begin
                if (idx < 8) chain_h[idx[2:0]] = val;
            end
            CMD_LOAD_M: begin
                msg_m[idx] = val;
            end
            CMD_LOAD_T: begin
                if (idx < 4) ctr_t[idx[1:0]] = val;
            end
            default: begin
                compress_block();
            end
        endcase
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return ONES;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [3:0] pick_index(cmd_t cmd);
        if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
        case (cmd)
            CMD_LOAD_H: return 4'($urandom_range(0, 7));
            CMD_LOAD_T: return 4'($urandom_range(0, 3));
            default:    return 4'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic send_request(cmd_t cmd, logic [3:0] idx, logic [63:0] val);
        s_tvalid <= 1'b1;
        s_tuser  <= {idx, cmd};
        s_tdata  <= val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(cmd, idx, val);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    initial begin
        int   sent;
        int   nloads;
        cmd_t cmd;
        logic [3:0] idx;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every stored word written once before any compress
        for (int i = 0; i < 8; i++) send_request(CMD_LOAD_H, 4'(i), 64'd0);
        for (int i = 0; i < 16; i++) send_request(CMD_LOAD_M, 4'(i), 64'd0);
        for (int i = 0; i < 4; i++) send_request(CMD_LOAD_T, 4'(i), 64'd0);

        foreach (DIRECTED[k]) begin
            send_request(DIRECTED[k].cmd, DIRECTED[k].idx, DIRECTED[k].val);
        end

        sent = 0;
        while (sent < RANDOM_REQS) begin
            nloads = $urandom_range(0, 12);
            for (int j = 0; j < nloads; j++) begin
                cmd = cmd_t'(2'($urandom_range(0, 2)));
                idx = pick_index(cmd);
                send_request(cmd, idx, rand_word());
                if ((cmd == CMD_LOAD_M) || (cmd == CMD_LOAD_H && idx < 8) ||
                    (cmd == CMD_LOAD_T && idx < 4)) sent++;
            end
            send_request(CMD_COMPRESS, 4'($urandom_range(0, 15)), rand_word());
            sent++;
            if (sent >= CALM_AFTER) calm = 1'b1;
        end
        s_tvalid <= 1'b0;

        while (expected_words.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // result side backpressure in bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!calm && aresetn && $urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 18);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        hash_word_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    $error("hash word with none pending: index %0d, value %h", m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_tuser !== want.idx) begin
                        $error("hash_index mismatch: expected %0d, actual %0d", want.idx, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata !== want.value) begin
                        $error("hash_value mismatch: expected %h, actual %h", want.value, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule
